/* design/ali_pkg.sv */
// shared constants and types for the bounded list block
package ali_pkg;

  localparam int CAPACITY = 128;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int OCNT_W   = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // ram write request from the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
  } ram_wr_t;

endpackage

/* design/ali_ram.sv */
// list storage: one write port, one read port with registered read data
module ali_ram (
  input  logic             clk,
  input  ali_pkg::ram_wr_t wr,
  input  ali_pkg::addr_t   raddr,
  output ali_pkg::word_t   rdata
);
  import ali_pkg::*;

  word_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/array_list_insert_delete.sv */
// bounded ordered list of signed words with insert, delete and read at a position
// one op at a time: in_stall is high from the cycle after acceptance until the result
// register loads, which waits out any out_stall; next beat is taken in the cycle after that
// failed ops go straight to S_DONE, tail append via S_PUT, read via S_RUN
// insert/delete shifting n entries (n up to 127) does one ram read+write per cycle
// synchronous active-low reset clears count and control; ram contents are not cleared
module array_list_insert_delete (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ali_pkg::OP_W-1:0]      in_op,
  input  logic [ali_pkg::POS_W-1:0]     in_position,
  input  logic signed [ali_pkg::WORD_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [ali_pkg::WORD_W-1:0] out_read_value,
  output logic [ali_pkg::OCNT_W-1:0]    out_count
);
  import ali_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;  // streaming read/write walk over the ram
  localparam logic [1:0] S_PUT  = 2'd2;  // insert: write the new word into its slot
  localparam logic [1:0] S_DONE = 2'd3;  // result ready, waiting for the output register

  logic [1:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  addr_t           rd_ptr_r, rd_ptr_nxt;     // next address to read
  addr_t           end_r, end_nxt;           // last address to read; insert slot for S_PUT
  logic            dir_up_r, dir_up_nxt;     // insert moves entries up, delete moves down
  logic            first_r, first_nxt;       // first read returns the removed/read word
  logic            issue_r, issue_nxt;       // reads still to issue
  logic            pend_r, pend_nxt;         // a read was issued last cycle
  addr_t           pend_addr_r, pend_addr_nxt;
  word_t           value_r, value_nxt;
  word_t           res_r, res_nxt;
  logic            res_ok_r, res_ok_nxt;
  cnt_t            count_r, count_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_ok_r, out_ok_nxt;
  word_t           out_val_r, out_val_nxt;
  logic [OCNT_W-1:0] out_cnt_r, out_cnt_nxt;

  ram_wr_t         ram_wr;
  word_t           ram_rdata;

  logic            in_beat;
  logic            out_free;
  cnt_t            pos_c;

  ali_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_c    = CNT_W'(in_position);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rd_ptr_nxt    = rd_ptr_r;
    end_nxt       = end_r;
    dir_up_nxt    = dir_up_r;
    first_nxt     = first_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    value_nxt     = value_r;
    res_nxt       = res_r;
    res_ok_nxt    = res_ok_r;
    count_nxt     = count_r;
    ram_wr        = '0;

    // output register drains whenever the downstream takes the beat
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt     = in_op;
          value_nxt  = in_value;
          res_nxt    = '0;
          res_ok_nxt = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;          // failure path unless an arm below says otherwise
          unique case (in_op)
            OP_INSERT: begin
              if (count_r < CNT_W'(CAPACITY) && pos_c <= count_r) begin
                res_ok_nxt = 1'b1;
                end_nxt    = ADDR_W'(in_position);
                if (pos_c == count_r) begin
                  // append at the tail: nothing to shift
                  state_nxt = S_PUT;
                end else begin
                  rd_ptr_nxt = ADDR_W'(count_r - 1'b1);
                  dir_up_nxt = 1'b1;
                  first_nxt  = 1'b0;
                  issue_nxt  = 1'b1;
                  state_nxt  = S_RUN;
                end
              end
            end
            OP_DELETE, OP_READ: begin
              if (pos_c < count_r) begin
                res_ok_nxt = 1'b1;
                rd_ptr_nxt = ADDR_W'(in_position);
                // read stops after the addressed entry; delete walks to the tail
                end_nxt    = (in_op == OP_DELETE) ? ADDR_W'(count_r - 1'b1)
                                                  : ADDR_W'(in_position);
                dir_up_nxt = 1'b0;
                first_nxt  = 1'b1;
                issue_nxt  = 1'b1;
                state_nxt  = S_RUN;
              end
            end
            default: begin
              // unknown op fails with the list untouched
            end
          endcase
        end
      end

      S_RUN: begin
        // retire the read issued last cycle
        if (pend_r) begin
          if (first_r) begin
            res_nxt   = ram_rdata;
            first_nxt = 1'b0;
          end else begin
            ram_wr.we    = 1'b1;
            ram_wr.waddr = dir_up_r ? pend_addr_r + 1'b1 : pend_addr_r - 1'b1;
            ram_wr.wdata = ram_rdata;
          end
        end
        // issue the next read; write targets never collide with the read address
        if (issue_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_ptr_r;
          if (rd_ptr_r == end_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_ptr_nxt = dir_up_r ? rd_ptr_r - 1'b1 : rd_ptr_r + 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (op_r == OP_INSERT) begin
              state_nxt = S_PUT;
            end else begin
              if (op_r == OP_DELETE) begin
                count_nxt = count_r - 1'b1;
              end
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_PUT: begin
        ram_wr.we    = 1'b1;
        ram_wr.waddr = end_r;
        ram_wr.wdata = value_r;
        count_nxt    = count_r + 1'b1;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_val_nxt   = res_ok_r ? res_r : '0;
          out_cnt_nxt   = OCNT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and pointers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    end_r       <= end_nxt;
    dir_up_r    <= dir_up_nxt;
    pend_addr_r <= pend_addr_nxt;
    value_r     <= value_nxt;
    res_r       <= res_nxt;
    res_ok_r    <= res_ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_val_r   <= out_val_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_val_r;
  assign out_count      = out_cnt_r;

endmodule

/* design/ali_chk.sv */
// port-level checker for the bounded list block, bound to the top level
module ali_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_ok,
  input logic [ali_pkg::WORD_W-1:0]    out_read_value,
  input logic [ali_pkg::OCNT_W-1:0]    out_count
);
  import ali_pkg::*;

  // one operation at a time: an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous op still in flight");

  // a failed op carries a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_read_value == '0)
    else $error("failed op returned nonzero word");

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= OCNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok)
      && $stable(out_read_value) && $stable(out_count))
    else $error("stalled result beat changed");

endmodule

bind array_list_insert_delete ali_chk u_ali_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ok         (out_ok),
  .out_read_value (out_read_value),
  .out_count      (out_count)
);

/* tb/testbench.sv */
// self-checking testbench for the bounded ordered list block
`timescale 1ns / 100ps

module testbench;
  import ali_pkg::*;

  // op code 3 has no meaning in the block and must fail
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1750;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    logic                     ok;
    logic signed [WORD_W-1:0] read_value;
    logic [OCNT_W-1:0]        count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = OP_READ;
  logic [POS_W-1:0] in_position = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic signed [WORD_W-1:0] out_read_value;
  logic [OCNT_W-1:0] out_count;

  array_list_insert_delete u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  // commands waiting to be driven, and results the list should produce
  list_cmd_t    cmd_q[$];
  list_result_t expected_q[$];
  list_cmd_t    next_cmd;

  // shadow copy of the list contents, updated on every accepted beat
  logic signed [WORD_W-1:0] shadow_words[CAPACITY];
  int shadow_len = 0;

  // length tracked while building the stimulus, so positions can be aimed
  int gen_len = 0;

  int total_beats = 1;
  int beats_in = 0;
  int beats_out = 0;
  int fault_count = 0;

  initial forever #1 clk = ~clk;

  // run phases by progress: sender idles lightly then heavily, receiver the
  // opposite, and the last third runs with no idling at all
  function automatic int send_idle_pct();
    int phase;
    phase = beats_in * 3 / total_beats;
    return (phase == 0) ? 23 : (phase == 1) ? 61 : 0;
  endfunction

  function automatic int recv_idle_pct();
    int phase;
    phase = beats_in * 3 / total_beats;
    return (phase == 0) ? 61 : (phase == 1) ? 23 : 0;
  endfunction

  // apply one operation to the shadow list and return what the block should say
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                 logic signed [WORD_W-1:0] value);
    list_result_t res;
    int p;
    p = int'(pos);
    res.ok = 1'b0;
    res.read_value = '0;
    case (op)
      OP_INSERT: begin
        // full list, or a position past the end, leaves everything alone
        if (shadow_len < CAPACITY && p <= shadow_len) begin
          for (int i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = value;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p < shadow_len) begin
          res.read_value = shadow_words[p];
          for (int i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (p < shadow_len) begin
          res.read_value = shadow_words[p];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = shadow_len[OCNT_W-1:0];
    return res;
  endfunction

  // queue a command and keep the generator's idea of the length current
  task automatic push_cmd(input logic [OP_W-1:0] op, input int pos,
                          input logic signed [WORD_W-1:0] value);
    list_cmd_t c;
    c.op = op;
    c.pos = pos[POS_W-1:0];
    c.value = value;
    cmd_q.push_back(c);
    if (op == OP_INSERT && gen_len < CAPACITY && pos <= gen_len) gen_len++;
    else if (op == OP_DELETE && pos < gen_len) gen_len--;
  endtask

  // extremes show up often, otherwise any word
  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // a position in 0..hi, leaning toward the two ends
  function automatic int pick_pos(input int hi);
    if (hi > CAPACITY - 1) hi = CAPACITY - 1;
    case ($urandom_range(7))
      0: return 0;
      1: return hi;
      default: return $urandom_range(hi, 0);
    endcase
  endfunction

  task automatic report_fault(input string what, input longint want, input longint got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, beats_out, want, got);
  endtask

  // driver: presents the next command when the previous beat went through
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(apply_list_op(in_op, in_position, in_value));
        beats_in++;
      end
      // a stalled beat holds its payload; otherwise load a new one or go idle
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_cmd = cmd_q.pop_front();
          in_op <= next_cmd.op;
          in_position <= next_cmd.pos;
          in_value <= next_cmd.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_fault("result with nothing pending", 0, longint'(out_count));
        end else begin
          want = expected_q.pop_front();
          if (out_ok !== want.ok) report_fault("ok", want.ok, out_ok);
          if (out_read_value !== want.read_value)
            report_fault("read_value", want.read_value, out_read_value);
          if (out_count !== want.count) report_fault("count", want.count, out_count);
        end
        beats_out++;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  // stimulus, reset and end of run
  initial begin
    int iter;
    int mode;
    int r;
    int hi;
    logic [OP_W-1:0] op;

    // directed: empty-list failures, extremes, inserts at front, middle and end
    push_cmd(OP_READ, 0, 32'sh1234_5678);
    push_cmd(OP_DELETE, 0, '0);
    push_cmd(OP_INSERT, 1, 32'sh0BAD_0BAD);        // past the end of an empty list
    push_cmd(OP_UNUSED, 0, '1);
    push_cmd(OP_INSERT, 0, 32'sh7FFF_FFFF);
    push_cmd(OP_INSERT, 0, 32'sh8000_0000);
    push_cmd(OP_INSERT, 2, '1);                    // append
    push_cmd(OP_INSERT, 1, '0);                    // middle
    push_cmd(OP_INSERT, 5, 32'sh0000_0001);        // past the end
    push_cmd(OP_INSERT, CAPACITY - 1, 32'sh0000_0001);
    push_cmd(OP_READ, 0, '0);
    push_cmd(OP_READ, 3, '0);
    push_cmd(OP_READ, 4, '0);                      // one past the last entry
    push_cmd(OP_READ, CAPACITY - 1, '0);
    push_cmd(OP_DELETE, 1, '0);
    push_cmd(OP_DELETE, 2, '0);                    // last entry
    push_cmd(OP_DELETE, 2, '0);                    // now out of range
    push_cmd(OP_UNUSED, CAPACITY - 1, '1);
    push_cmd(OP_DELETE, 0, '0);
    push_cmd(OP_READ, 0, '0);
    push_cmd(OP_DELETE, 0, '0);                    // list empty again
    push_cmd(OP_INSERT, 0, 32'sh5555_5555);
    push_cmd(OP_INSERT, 1, 32'shAAAA_AAAA);

    // random: fill-to-full and drain-to-empty runs plus mixed noise
    iter = 0;
    while (cmd_q.size() < RANDOM_BEATS + 23) begin
      mode = (iter == 0) ? 0 : (iter == 1) ? 2 : $urandom_range(9);
      if (mode < 2) begin
        while (gen_len < CAPACITY) begin
          if (gen_len > 0 && $urandom_range(9) == 0)
            push_cmd(OP_READ, pick_pos(gen_len - 1), rand_word());
          else
            push_cmd(OP_INSERT, pick_pos(gen_len), rand_word());
        end
        // full list: inserts fail, the top entry can be read, removed and put back
        repeat (3) push_cmd(OP_INSERT, $urandom_range(CAPACITY - 1), rand_word());
        push_cmd(OP_READ, CAPACITY - 1, rand_word());
        push_cmd(OP_DELETE, CAPACITY - 1, rand_word());
        push_cmd(OP_INSERT, CAPACITY - 1, rand_word());
      end else if (mode < 4) begin
        while (gen_len > 0) begin
          if ($urandom_range(9) == 0)
            push_cmd(OP_READ, pick_pos(gen_len - 1), rand_word());
          else
            push_cmd(OP_DELETE, pick_pos(gen_len - 1), rand_word());
        end
        push_cmd(OP_DELETE, $urandom_range(CAPACITY - 1), rand_word());
        push_cmd(OP_READ, 0, rand_word());
      end else begin
        repeat ($urandom_range(60, 10)) begin
          r = $urandom_range(99);
          op = (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 96) ? OP_READ : OP_UNUSED;
          hi = (op == OP_INSERT) ? gen_len : gen_len - 1;
          // a fifth of positions are anywhere in the field, mostly out of range
          if (hi < 0 || $urandom_range(4) == 0)
            push_cmd(op, $urandom_range(CAPACITY - 1), rand_word());
          else
            push_cmd(op, pick_pos(hi), rand_word());
        end
      end
      iter++;
    end
    total_beats = cmd_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sampled away from the active edge so driver and monitor updates have settled
    while (beats_in < total_beats || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fault_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
